// ===== rtl/core/dvru_pkg.sv =====
// Shared types, widths and outcome codes for the distance-vector route update block.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package dvru_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   localparam int ADDR_W    = 32;
   localparam int COST_W    = 8;
   localparam int OUTCOME_W = 3;
   localparam int SLOT_W    = 6;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 24;

   localparam logic [OUTCOME_W-1:0] OUT_UNCHANGED = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_REFRESHED = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_IMPROVED  = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_ADDED     = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd4;

   localparam logic [COST_W-1:0] COST_MAX = 8'hFF;
   localparam logic [COST_W-1:0] COST_ONE = 8'h01;

   typedef struct packed {
      logic [ADDR_W-1:0] dest;
      logic [ADDR_W-1:0] next_hop;
      logic [ADDR_W-1:0] iface;
      logic [COST_W-1:0] cost;
   } dvru_entry_type;

   typedef struct packed {
      logic                 valid;
      logic [OUTCOME_W-1:0] outcome;
      logic [SLOT_W-1:0]    slot;
      logic [COST_W-1:0]    cost;
   } dvru_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/dvru_table.sv =====
// Route table storage: one write port and one read port with registered read data.
// Depends on dvru_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module dvru_table #(
   parameter int TABLE_ENTRIES = dvru_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output dvru_pkg::dvru_entry_type           rd_data,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  wire dvru_pkg::dvru_entry_type      wr_data
);

   dvru_pkg::dvru_entry_type mem [TABLE_ENTRIES];
   dvru_pkg::dvru_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dvru_ctrl.sv =====
// Sequencer that scans the route table one entry per cycle and applies the update.
// Depends on dvru_pkg; drives the ports of dvru_table.
`timescale 1ns / 1ps
`default_nettype none

module dvru_ctrl #(
   parameter int TABLE_ENTRIES = dvru_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [dvru_pkg::ADDR_W-1:0]       req_neighbor_addr,
   input  wire logic [dvru_pkg::ADDR_W-1:0]       req_arrival_interface,
   input  wire logic [dvru_pkg::ADDR_W-1:0]       req_adv_dest,
   input  wire logic [dvru_pkg::COST_W-1:0]       req_adv_cost,
   output dvru_pkg::dvru_result_type              res,
   input  wire logic                              out_free,
   output logic                                   rd_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]       rd_addr,
   input  wire dvru_pkg::dvru_entry_type          rd_data,
   output logic                                   wr_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]       wr_addr,
   output dvru_pkg::dvru_entry_type               wr_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [dvru_pkg::ADDR_W-1:0]      from_ff, from_in;
   logic [dvru_pkg::ADDR_W-1:0]      recv_ff, recv_in;
   logic [dvru_pkg::ADDR_W-1:0]      dest_ff, dest_in;
   logic [dvru_pkg::COST_W-1:0]      via_ff, via_in;
   logic                             self_ff, self_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [CNT_W-1:0]                 addr_ff, addr_in;
   logic [IDX_W-1:0]                 cmp_idx_ff, cmp_idx_in;
   logic                             cmp_valid_ff, cmp_valid_in;
   logic [dvru_pkg::OUTCOME_W-1:0]   outcome_ff, outcome_in;
   logic [dvru_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [dvru_pkg::COST_W-1:0]      cost_ff, cost_in;

   always_comb begin
      state_in     = state_ff;
      from_in      = from_ff;
      recv_in      = recv_ff;
      dest_in      = dest_ff;
      via_in       = via_ff;
      self_in      = self_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      outcome_in   = outcome_ff;
      slot_in      = slot_ff;
      cost_in      = cost_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cmp_idx_ff;
      wr_data      = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               from_in      = req_neighbor_addr;
               recv_in      = req_arrival_interface;
               dest_in      = req_adv_dest;
               via_in       = (req_adv_cost == dvru_pkg::COST_MAX) ? dvru_pkg::COST_MAX
                                                                   : req_adv_cost + dvru_pkg::COST_ONE;
               self_in      = (req_neighbor_addr == req_adv_dest);
               addr_in      = '0;
               cmp_valid_in = 1'b0;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmp_valid_in = 1'b0;
            if (addr_ff < count_ff) begin
               rd_en        = 1'b1;
               addr_in      = addr_ff + 1'b1;
               cmp_idx_in   = addr_ff[IDX_W-1:0];
               cmp_valid_in = 1'b1;
            end
            if (cmp_valid_ff && (rd_data.dest == dest_ff)) begin
               state_in = ST_DONE;
               slot_in  = dvru_pkg::SLOT_W'(cmp_idx_ff);
               if (rd_data.next_hop == from_ff) begin
                  wr_en        = 1'b1;
                  wr_data.cost = via_ff;
                  outcome_in   = dvru_pkg::OUT_REFRESHED;
                  cost_in      = via_ff;
               end else if (via_ff < rd_data.cost) begin
                  wr_en            = 1'b1;
                  wr_data.next_hop = from_ff;
                  wr_data.iface    = recv_ff;
                  wr_data.cost     = via_ff;
                  outcome_in       = dvru_pkg::OUT_IMPROVED;
                  cost_in          = via_ff;
               end else begin
                  outcome_in = dvru_pkg::OUT_UNCHANGED;
                  cost_in    = rd_data.cost;
               end
            end else if (!cmp_valid_ff && (addr_ff == count_ff)) begin
               state_in = ST_DONE;
               if (count_ff < CNT_W'(TABLE_ENTRIES)) begin
                  wr_en            = 1'b1;
                  wr_addr          = count_ff[IDX_W-1:0];
                  wr_data.dest     = dest_ff;
                  wr_data.next_hop = from_ff;
                  wr_data.iface    = recv_ff;
                  wr_data.cost     = self_ff ? dvru_pkg::COST_ONE : via_ff;
                  count_in         = count_ff + 1'b1;
                  outcome_in       = dvru_pkg::OUT_ADDED;
                  slot_in          = dvru_pkg::SLOT_W'(count_ff);
                  cost_in          = self_ff ? dvru_pkg::COST_ONE : via_ff;
               end else begin
                  outcome_in = dvru_pkg::OUT_FULL;
                  slot_in    = '0;
                  cost_in    = '0;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      from_ff    <= from_in;
      recv_ff    <= recv_in;
      dest_ff    <= dest_in;
      via_ff     <= via_in;
      self_ff    <= self_in;
      cmp_idx_ff <= cmp_idx_in;
      outcome_ff <= outcome_in;
      slot_ff    <= slot_in;
      cost_ff    <= cost_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rd_addr     = addr_ff[IDX_W-1:0];
   assign res.valid   = (state_ff == ST_DONE);
   assign res.outcome = outcome_ff;
   assign res.slot    = slot_ff;
   assign res.cost    = cost_ff;

endmodule

`default_nettype wire

// ===== rtl/core/distance_vector_route_update.sv =====
// The table scan reads one entry per cycle from a single read port, so the time per item grows
// with the number of routes in the table; a new request beat is taken only once the previous
// result has been loaded into the result register, so items are not overlapped.
// Reset is synchronous and active high; it empties the route table and the result register.
// Top level of the route update block; depends on dvru_pkg, dvru_ctrl and dvru_table.
// Holds the result register and splits the request beat into its fields.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_route_update #(
   parameter int TABLE_ENTRIES = dvru_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // neighbor_addr[31:0], arrival_interface[63:32], adv_dest[95:64], adv_cost[103:96]
   input  wire logic [dvru_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // outcome[2:0], slot[8:3], route_cost[16:9], zero[23:17]
   output logic [dvru_pkg::RSP_DATA_W-1:0]          rsp_tdata
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   dvru_pkg::dvru_result_type       res;
   dvru_pkg::dvru_entry_type        rd_data;
   dvru_pkg::dvru_entry_type        wr_data;
   logic                            rd_en;
   logic                            wr_en;
   logic [IDX_W-1:0]                rd_addr;
   logic [IDX_W-1:0]                wr_addr;
   logic                            out_free;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dvru_pkg::OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [dvru_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [dvru_pkg::COST_W-1:0]     rsp_cost_ff, rsp_cost_in;

   dvru_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_tvalid),
      .req_ready            (req_tready),
      .req_neighbor_addr    (req_tdata[31:0]),
      .req_arrival_interface(req_tdata[63:32]),
      .req_adv_dest         (req_tdata[95:64]),
      .req_adv_cost         (req_tdata[103:96]),
      .res                  (res),
      .out_free             (out_free),
      .rd_en                (rd_en),
      .rd_addr              (rd_addr),
      .rd_data              (rd_data),
      .wr_en                (wr_en),
      .wr_addr              (wr_addr),
      .wr_data              (wr_data)
   );

   dvru_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_cost_in    = rsp_cost_ff;
      if (res.valid && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_outcome_in = res.outcome;
         rsp_slot_in    = res.slot;
         rsp_cost_in    = res.cost;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_cost_ff    <= rsp_cost_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cost_ff, rsp_slot_ff, rsp_outcome_ff};

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Block accepted a request beat while still processing one.");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (res.outcome == dvru_pkg::OUT_UNCHANGED ||
                     res.outcome == dvru_pkg::OUT_REFRESHED ||
                     res.outcome == dvru_pkg::OUT_IMPROVED  ||
                     res.outcome == dvru_pkg::OUT_ADDED     ||
                     res.outcome == dvru_pkg::OUT_FULL))
      else $error("Result carries an undefined outcome code.");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.outcome == dvru_pkg::OUT_FULL) |-> (res.slot == '0 && res.cost == '0))
      else $error("Table full result has nonzero slot or cost.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (res.valid && out_free) |=> rsp_tvalid)
      else $error("Finished result was not loaded into the output register.");

endmodule

`default_nettype wire
